// ===== src/sm4_derived_word_cipher_assert.svh =====
// Assertion macros for the checker file of the derived-word cipher.
`ifndef SM4_DERIVED_WORD_CIPHER_ASSERT_SVH
`define SM4_DERIVED_WORD_CIPHER_ASSERT_SVH

// Checked at every rising edge of clk once reset is released.
`define SM4DW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define SM4DW_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/sm4dw_pkg.sv =====
// Package with the constants, stage types and S-box of the derived-word cipher.
package sm4dw_pkg;

    localparam int WordWidth = 32;
    localparam int Rounds    = 5;

    localparam logic [WordWidth-1:0] FK_WORD = 32'ha3b1bac6;

    localparam logic [WordWidth-1:0] CK_WORDS [Rounds] = '{
        32'h00070e15, 32'h1c232a31, 32'h383f464d, 32'h545b6269, 32'h70777e85
    };

    localparam logic [2047:0] SBOX_TABLE = {
        128'hd690e9fecce13db716b614c228fb2c05,
        128'h2b679a762abe04c3aa441326498606_99,
        128'h9c4250f491ef987a33540b43edcfac62,
        128'he4b31ca9c908e89580df94fa758f3fa6,
        128'h4707a7fcf37317ba83593c19e6854fa8,
        128'h686b81b27164da8bf8eb0f4b70569d35,
        128'h1e240e5e6358d1a225227c3b01217887,
        128'hd40046579fd327524c3602e7a0c4c89e,
        128'heabf8ad240c738b5a3f7f2cef96115a1,
        128'he0ae5da49b341a55ad933230f58cb1e3,
        128'h1df6e22e8266ca60c02923ab0d534e6f,
        128'hd5db3745defd8e2f03ff6a726d6c5b51,
        128'h8d1baf92bbddbc7f11d95c411f105ad8,
        128'h0ac13188a5cd7bbd2d74d012b8e5b4b0,
        128'h8969974a0c96777e65b9f109c56ec684,
        128'h18f07dec3adc4d2079ee5f3ed7cb3948
    };

    typedef struct packed {
        logic [WordWidth-1:0]             data;
        logic [Rounds-1:0][WordWidth-1:0] round_key;
    } key_stage_t;

    typedef struct packed {
        logic [WordWidth-1:0]             data;
        logic [Rounds-1:0][WordWidth-1:0] tau;
    } sbox_stage_t;

    // Constant mask that turns the key word into round key r.
    function automatic logic [WordWidth-1:0] round_mask(input int r);
        logic [WordWidth-1:0] mask;
        mask = FK_WORD;
        for (int i = 0; i < Rounds; i++)
        begin
            if (i <= r)
            begin
                mask = mask ^ CK_WORDS[i];
            end
        end
        return mask;
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [10:0] base;
        base = {~x, 3'b000};
        return SBOX_TABLE[base +: 8];
    endfunction

endpackage

// ===== src/sm4dw_key_stage.sv =====
// First pipeline stage: forms the five round keys from the key word.
module sm4dw_key_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [sm4dw_pkg::WordWidth-1:0] data_word,
    input  logic [sm4dw_pkg::WordWidth-1:0] key_word,
    output logic                            out_valid,
    input  logic                            out_ready,
    output sm4dw_pkg::key_stage_t           out_stage
);

    logic                  valid_reg;
    sm4dw_pkg::key_stage_t stage_reg;
    sm4dw_pkg::key_stage_t stage_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        stage_next.data = data_word;
        for (int r = 0; r < sm4dw_pkg::Rounds; r++)
        begin
            stage_next.round_key[r] = key_word ^ sm4dw_pkg::round_mask(r);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

// ===== src/sm4dw_sbox_stage.sv =====
// Second pipeline stage: applies the S-box to every byte of each round key.
module sm4dw_sbox_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  sm4dw_pkg::key_stage_t  in_stage,
    output logic                   out_valid,
    input  logic                   out_ready,
    output sm4dw_pkg::sbox_stage_t out_stage
);

    logic                   valid_reg;
    sm4dw_pkg::sbox_stage_t stage_reg;
    sm4dw_pkg::sbox_stage_t stage_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        stage_next.data = in_stage.data;
        for (int r = 0; r < sm4dw_pkg::Rounds; r++)
        begin
            for (int b = 0; b < 4; b++)
            begin
                stage_next.tau[r][8*b +: 8] = sm4dw_pkg::sbox(in_stage.round_key[r][8*b +: 8]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

// ===== src/sm4dw_mix_stage.sv =====
// Last pipeline stage: linear transform of each word and the XOR onto the data word.
module sm4dw_mix_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  sm4dw_pkg::sbox_stage_t          in_stage,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sm4dw_pkg::WordWidth-1:0] result
);

    logic                            valid_reg;
    logic [sm4dw_pkg::WordWidth-1:0] result_reg;
    logic [sm4dw_pkg::WordWidth-1:0] result_next;

    function automatic logic [sm4dw_pkg::WordWidth-1:0] linear(
        input logic [sm4dw_pkg::WordWidth-1:0] b
    );
        return b
             ^ {b[29:0], b[31:30]}
             ^ {b[21:0], b[31:22]}
             ^ {b[13:0], b[31:14]}
             ^ {b[7:0],  b[31:8]};
    endfunction

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        result_next = in_stage.data;
        for (int r = 0; r < sm4dw_pkg::Rounds; r++)
        begin
            result_next = result_next ^ linear(in_stage.tau[r]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;

endmodule

// ===== src/sm4_derived_word_cipher.sv =====
// Top level of the derived-word cipher: a three-stage pipeline.
//
//   Channel   Signals                                          Direction
//   input     in_valid, in_ready, data_word, key_word          into the block
//   output    out_valid, out_ready, result_word                out of the block
//
// A result passes the key, S-box and mix stage registers before it is valid at the output.
// One item per cycle while out_ready stays high. The stages are round key forming,
// S-box lookup, and linear transform with the XOR tree.
// Each stage holds its own valid bit, which reset clears; no data register is reset.
// A stalled output holds its result, and earlier stages keep filling empty slots.
module sm4_derived_word_cipher (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [sm4dw_pkg::WordWidth-1:0] data_word,
    input  logic [sm4dw_pkg::WordWidth-1:0] key_word,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sm4dw_pkg::WordWidth-1:0] result_word
);

    logic                   key_valid;
    logic                   key_ready;
    sm4dw_pkg::key_stage_t  key_stage;
    logic                   sbox_valid;
    logic                   sbox_ready;
    sm4dw_pkg::sbox_stage_t sbox_stage;

    sm4dw_key_stage u_key_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_word (data_word),
        .key_word  (key_word),
        .out_valid (key_valid),
        .out_ready (key_ready),
        .out_stage (key_stage)
    );

    sm4dw_sbox_stage u_sbox_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (key_valid),
        .in_ready  (key_ready),
        .in_stage  (key_stage),
        .out_valid (sbox_valid),
        .out_ready (sbox_ready),
        .out_stage (sbox_stage)
    );

    sm4dw_mix_stage u_mix_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sbox_valid),
        .in_ready  (sbox_ready),
        .in_stage  (sbox_stage),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result_word)
    );

endmodule

// ===== src/sm4dw_checker.sv =====
// Port checker for the derived-word cipher and its bind to the top level.
`include "sm4_derived_word_cipher_assert.svh"

module sm4dw_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic [sm4dw_pkg::WordWidth-1:0] data_word,
    input logic [sm4dw_pkg::WordWidth-1:0] key_word,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [sm4dw_pkg::WordWidth-1:0] result_word
);

    `SM4DW_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "Output valid after reset.")

    `SM4DW_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid && $stable({data_word, key_word}), "Input changed.")

    `SM4DW_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(result_word), "Result changed.")

    `SM4DW_ASSERT(a_empty_ready, !out_valid |-> in_ready, "Input stalled with an empty pipe.")

    `SM4DW_ASSERT(a_latency, (in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid, "Result late.")

endmodule

bind sm4_derived_word_cipher sm4dw_checker u_sm4dw_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_word   (data_word),
    .key_word    (key_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_word (result_word)
);

// ===== tb/sm4_derived_word_cipher_test.sv =====
// Testbench for the derived-word SM4 cipher: directed, random and backpressure transfers.
`timescale 1ns / 100ps

module sm4_derived_word_cipher_test;

    localparam int CycleLimit = 200000;
    localparam int DrainCycles = 8;
    localparam int RandomPerPhase = 630;
    localparam int StallCycles = 400;
    localparam int StallItems = 40;
    localparam int ReportLimit = 10;

    localparam logic [31:0] SM4_FK = 32'ha3b1bac6;
    localparam logic [31:0] SM4_CK [5] = '{
        32'h00070e15, 32'h1c232a31, 32'h383f464d, 32'h545b6269, 32'h70777e85
    };

    localparam logic [7:0] SM4_SBOX [256] = '{
        8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
        8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
        8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
        8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
        8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
        8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
        8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
        8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
        8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
        8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
        8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
        8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
        8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
        8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
        8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
        8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
        8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
        8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
        8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
        8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
        8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
        8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
        8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
        8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
        8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
        8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
        8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
        8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
        8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
        8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
        8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
        8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
    };

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [sm4dw_pkg::WordWidth-1:0] data_word = '0;
    logic [sm4dw_pkg::WordWidth-1:0] key_word = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [sm4dw_pkg::WordWidth-1:0] result_word;

    logic [31:0] expected_words [$];
    logic [31:0] wanted_word;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          stall_left = 0;
    int          fault_count = 0;
    int          cycle_count = 0;

    sm4_derived_word_cipher i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_word   (data_word),
        .key_word    (key_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_word (result_word)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] round_transform(input logic [31:0] x);
        logic [31:0] b;
        b = {SM4_SBOX[x[31:24]], SM4_SBOX[x[23:16]], SM4_SBOX[x[15:8]], SM4_SBOX[x[7:0]]};
        return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                 ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
    endfunction

    function automatic logic [31:0] cipher_word(input logic [31:0] data, input logic [31:0] key);
        logic [31:0] acc;
        logic [31:0] rk;
        acc = data;
        rk = key ^ SM4_FK;
        for (int r = 0; r < 5; r++)
        begin
            rk = rk ^ SM4_CK[r];
            acc = acc ^ round_transform(rk);
        end
        return acc;
    endfunction

    task automatic send_word(input logic [31:0] data, input logic [31:0] key);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_word <= data;
        key_word <= key;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        expected_words.push_back(cipher_word(data, key));
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic test_directed;
        send_word(32'h00000000, 32'h00000000);
        send_word(32'hffffffff, 32'hffffffff);
        send_word(32'h00000000, 32'hffffffff);
        send_word(32'hffffffff, 32'h00000000);
        send_word(32'ha5a5a5a5, 32'h5a5a5a5a);
        send_word(32'h5a5a5a5a, 32'ha5a5a5a5);
        send_word(32'h80000000, 32'h00000001);
        send_word(32'h00000001, 32'h80000000);
        // Keys built from FK and CK; all but the first make one of the round keys all zeros or all ones.
        send_word(32'h00000000, SM4_FK);
        send_word(32'h00000000, SM4_FK ^ SM4_CK[0]);
        send_word(32'hffffffff, ~(SM4_FK ^ SM4_CK[0]));
        send_word(32'h12345678, SM4_FK ^ SM4_CK[0] ^ SM4_CK[1]);
        send_word(32'h87654321, SM4_FK ^ SM4_CK[0] ^ SM4_CK[1] ^ SM4_CK[2]);
        send_word(32'hdeadbeef,
                  SM4_FK ^ SM4_CK[0] ^ SM4_CK[1] ^ SM4_CK[2] ^ SM4_CK[3] ^ SM4_CK[4]);
        send_word(32'h0f0f0f0f, 32'hf0f0f0f0);
        send_word(32'hf0f0f0f0, 32'h0f0f0f0f);
        drain();
    endtask

    task automatic test_random(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        repeat (RandomPerPhase) send_word($urandom, $urandom);
        drain();
    endtask

    task automatic test_backpressure;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_left <= StallCycles;
        repeat (StallItems) send_word($urandom, $urandom);
        drain();
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                fault_count++;
                if (fault_count <= ReportLimit)
                begin
                    $display("Result %h arrived with no transfer outstanding.", result_word);
                end
            end
            else
            begin
                wanted_word = expected_words.pop_front();
                if (result_word !== wanted_word)
                begin
                    fault_count++;
                    if (fault_count <= ReportLimit)
                    begin
                        $display("result_word mismatch: expected %h, actual %h.",
                                 wanted_word, result_word);
                    end
                end
            end
        end
        out_ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(14, 72);
        test_random(72, 14);
        test_random(0, 0);
        test_backpressure();
        if (fault_count == 0 && expected_words.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/sm4dw_pkg.sv
src/sm4dw_key_stage.sv
src/sm4dw_sbox_stage.sv
src/sm4dw_mix_stage.sv
src/sm4_derived_word_cipher.sv
src/sm4dw_checker.sv
tb/sm4_derived_word_cipher_test.sv
